FILE: rtl/licr_pkg.sv
`timescale 1ns / 1ps
package licr_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W       = $clog2(MAX_RESULTS);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CNT_W-1:0]           run_cnt_t;

endpackage

FILE: rtl/linear_interp_capture_resampler.sv
`timescale 1ns / 1ps
// channel   | dir | tdata [lsb up]        | tlast       | notes
// s_axis    | in  | in_sample [15:0]      | -           | one sample per beat
// m_axis    | out | out_sample [15:0]     | last_of_run | 0..8 beats per input
// cfg       | in  | step_ratio            | -           | write when idle
// One input beat per cycle while m_axis does not stall and each sample
// yields at most one output beat. A sample with N outputs (N <= 8) holds
// the run stage while one interpolation multiplier makes one output per
// cycle unless m_axis stalls; a sample with no output never waits on it.
// arst_n clears phase, previous sample, step (to 1.0) and all valids.
// m_axis stall backs up through the run stage to s_axis_tready.
module linear_interp_capture_resampler #(
	parameter int PHASE_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [PHASE_FRAC_BITS+3:0]    cfg_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [15:0]                   s_axis_tdata,   // [15:0] in_sample
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [15:0]                   m_axis_tdata,   // [15:0] out_sample
	output logic                          m_axis_tlast    // last_of_run
);

	localparam int PF = PHASE_FRAC_BITS;
	localparam int PW = PF + 4;
	localparam logic [PW-1:0] PHASE_ONE = {4'b0001, {PF{1'b0}}};
	localparam licr_pkg::run_cnt_t CNT_LAST = licr_pkg::CNT_W'(licr_pkg::MAX_RESULTS - 1);

	logic [PW-1:0]       step_q;
	logic [PW-1:0]       phase_q;
	licr_pkg::sample_t   prev_q;
	logic                have_prev_q;

	logic                valid_s1;
	licr_pkg::sample_t   cur_s1;
	licr_pkg::run_cnt_t  cnt_s1;

	logic                out_valid_q;
	licr_pkg::sample_t   out_data_q;
	logic                out_last_q;

	logic [PW:0]         sum;
	logic [PW-1:0]       next_phase;
	logic [PW-1:0]       fin_phase;
	logic                in_run;
	logic                slot_free;
	logic                emit;
	logic                run_end;
	logic                done;
	logic                accept;
	licr_pkg::sample_t   interp_y;

	assign sum        = {1'b0, phase_q} + {1'b0, step_q};
	assign next_phase = sum[PW] ? {PW{1'b1}} : sum[PW-1:0];
	assign fin_phase  = (next_phase >= PHASE_ONE) ? (next_phase - PHASE_ONE) : '0;
	assign in_run     = valid_s1 && (phase_q < PHASE_ONE);
	assign slot_free  = !out_valid_q || m_axis_tready;
	assign emit       = in_run && slot_free;
	assign run_end    = (next_phase >= PHASE_ONE) || (cnt_s1 == CNT_LAST);
	assign done       = valid_s1 && (!in_run || (emit && run_end));
	assign s_axis_tready = !valid_s1 || done;
	assign accept     = s_axis_tvalid && s_axis_tready;

	licr_interp #(
		.PHASE_FRAC_BITS(PHASE_FRAC_BITS)
	) u_interp (
		.prev (prev_q),
		.cur  (cur_s1),
		.frac (phase_q[PF-1:0]),
		.y    (interp_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= PHASE_ONE;
			phase_q     <= '0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			valid_s1    <= 1'b0;
			cnt_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				step_q <= cfg_data;
			end

			if (valid_s1) begin
				if (!in_run) begin
					phase_q <= phase_q - PHASE_ONE;
				end else if (emit) begin
					phase_q <= run_end ? fin_phase : next_phase;
				end
			end

			if (done) begin
				prev_q <= cur_s1;
			end

			if (accept && !have_prev_q) begin
				prev_q      <= s_axis_tdata;
				have_prev_q <= 1'b1;
			end

			if (accept && have_prev_q) begin
				valid_s1 <= 1'b1;
				cnt_s1   <= '0;
			end else begin
				if (done) begin
					valid_s1 <= 1'b0;
				end
				if (emit) begin
					cnt_s1 <= cnt_s1 + 1'b1;
				end
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && have_prev_q) begin
			cur_s1 <= s_axis_tdata;
		end
		if (emit) begin
			out_data_q <= interp_y;
			out_last_q <= run_end;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

FILE: rtl/licr_interp.sv
`timescale 1ns / 1ps
module licr_interp #(
	parameter int PHASE_FRAC_BITS = 16
) (
	input  licr_pkg::sample_t            prev,
	input  licr_pkg::sample_t            cur,
	input  logic [PHASE_FRAC_BITS-1:0]   frac,
	output licr_pkg::sample_t            y
);

	localparam int PF = PHASE_FRAC_BITS;
	localparam int NW = PF + licr_pkg::SAMPLE_W + 2;

	logic signed [licr_pkg::SAMPLE_W:0] diff;
	logic signed [NW-1:0]               base;
	logic signed [NW-1:0]               prod;
	logic signed [NW-1:0]               num;
	logic signed [NW-1:0]               bias;
	logic signed [NW-1:0]               adj;

	// prev * 1.0 + frac * (cur - prev), then divide by 1.0 rounding toward zero
	assign diff = {cur[licr_pkg::SAMPLE_W-1], cur} - {prev[licr_pkg::SAMPLE_W-1], prev};
	assign base = {{2{prev[licr_pkg::SAMPLE_W-1]}}, prev, {PF{1'b0}}};
	assign prod = $signed({1'b0, frac}) * diff;
	assign num  = base + prod;
	assign bias = num[NW-1] ? {{(NW-PF){1'b0}}, {PF{1'b1}}} : '0;
	assign adj  = num + bias;
	assign y    = adj[PF+licr_pkg::SAMPLE_W-1:PF];

endmodule

FILE: rtl/licr_checker.sv
`timescale 1ns / 1ps
module licr_checker #(
	parameter int PHASE_FRAC_BITS = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic [PHASE_FRAC_BITS+3:0]    cfg_data,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [15:0]                   m_axis_tdata,
	input logic                          m_axis_tlast
);

	localparam int PF = PHASE_FRAC_BITS;
	localparam int PW = PF + 4;
	localparam logic [PW-1:0] PHASE_ONE = {4'b0001, {PF{1'b0}}};
	localparam logic [licr_pkg::CNT_W:0] RUN_MAX =
		(licr_pkg::CNT_W + 1)'(licr_pkg::MAX_RESULTS - 1);

	logic [PW-1:0]              step_q;
	logic [licr_pkg::CNT_W:0]   run_q;
	logic                       step_ge_one;

	assign step_ge_one = (step_q >= PHASE_ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= PHASE_ONE;
			run_q  <= '0;
		end else begin
			if (cfg_we) begin
				step_q <= cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				run_q <= m_axis_tlast ? '0 : run_q + 1'b1;
			end
		end
	end

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// a step of 1.0 or more yields at most one output per sample
	a_single_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && step_ge_one |-> m_axis_tlast)
		else $error("multi-beat run with step >= 1.0");

	// with one output per sample, input only stalls behind a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready && step_ge_one |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output back-pressure");

	// no run longer than the result limit
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> run_q < RUN_MAX)
		else $error("run exceeds result limit");

endmodule

bind linear_interp_capture_resampler licr_checker #(
	.PHASE_FRAC_BITS(PHASE_FRAC_BITS)
) u_licr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_we        (cfg_we),
	.cfg_data      (cfg_data),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
